// File: hdl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants for the count-min sketch with conservative update.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int HASH_W         = 64;
    localparam int INC_W          = 32;
    localparam int EST_W          = 32;
    localparam int TOTAL_W        = 64;
    // hash bits folded into the column remainder per cycle
    localparam int COL_DIGIT_BITS = 8;

    localparam logic [EST_W-1:0] EST_MAX = '1;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_ESTIMATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COL,
        ST_MIN,
        ST_TGT,
        ST_UPD
    } cms_state_t;

    // per-bank control from the sequencer
    typedef struct packed {
        logic rd;
        logic clear;
        logic raise;
    } cms_bank_ctl_t;

endpackage

// File: hdl/count_min_sketch_conservative_unit.sv
// ----------------------------------------------------------------------------
// count_min_sketch_conservative_unit
// Count-min sketch with conservative update over ROWS banks of counters.
// ----------------------------------------------------------------------------
// Each request carries a precomputed 128-bit key hash split in two halves; row
// r uses column (hash_first + r * hash_second) mod ROW_WIDTH. One request is
// worked at a time. When ROW_WIDTH is not a power of two, the column unit
// folds 8 hash bits per cycle into the remainder over the whole 64-bit hash.
// The rest is one read and one write back per row bank (all rows in parallel),
// a minimum tree step and a target step. The next request is taken while a
// finished result waits on the output. After reset the counter banks are
// cleared, one address per cycle in all banks at once, through every address
// up to ROW_WIDTH - 1; no request is taken until then.
// ----------------------------------------------------------------------------
module count_min_sketch_conservative_unit
    import cms_pkg::*;
#(
    parameter int ROWS         = 6,
    parameter int ROW_WIDTH    = 1024,
    parameter int COUNTER_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [HASH_W-1:0]  hash_first,
    input  logic [HASH_W-1:0]  hash_second,
    input  logic [INC_W-1:0]   increment,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [EST_W-1:0]   estimate,
    output logic [TOTAL_W-1:0] total
);

    localparam int CW          = $clog2(ROW_WIDTH);
    localparam int TREE_LEAVES = 2 ** $clog2(ROWS);
    localparam int SUM_W       = 65;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;
    localparam logic [CW-1:0] LAST_ADDR = CW'(ROW_WIDTH - 1);

    cms_state_t state_reg, state_next;

    logic [CW-1:0]           clr_addr_reg, clr_addr_next;
    logic                    out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic                    cmd_reg;
    logic [INC_W-1:0]        inc_reg;
    logic [COUNTER_BITS-1:0] min_reg, min_next;
    logic [COUNTER_BITS-1:0] target_reg, target_next;
    logic [EST_W-1:0]        estimate_reg, estimate_next;

    logic                              col_start;
    logic                              col_busy;
    logic [ROWS-1:0][CW-1:0]           col;
    logic [ROWS-1:0][COUNTER_BITS-1:0] rd_data;
    cms_bank_ctl_t                     bank_ctl;
    logic                              slot_free;
    logic                              upd_fire;
    logic [SUM_W-1:0]                  sum;
    logic [HASH_W-1:0]                 min_wide;
    logic [COUNTER_BITS-1:0]           tree [1:2*TREE_LEAVES-1];

    cms_colmod #(
        .ROWS      (ROWS),
        .ROW_WIDTH (ROW_WIDTH)
    ) u_colmod (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (col_start),
        .hash_first  (hash_first),
        .hash_second (hash_second),
        .busy        (col_busy),
        .col         (col)
    );

    for (genvar r = 0; r < ROWS; r++)
    begin : g_bank
        logic [CW-1:0] bank_addr;

        assign bank_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : col[r];

        cms_bank #(
            .ROW_WIDTH    (ROW_WIDTH),
            .COUNTER_BITS (COUNTER_BITS)
        ) u_bank (
            .clk     (clk),
            .ctl     (bank_ctl),
            .addr    (bank_addr),
            .target  (target_reg),
            .rd_data (rd_data[r])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_COL;
                end
            end
            ST_COL:
            begin
                if (!col_busy)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:  state_next = ST_TGT;
            ST_TGT:  state_next = ST_UPD;
            ST_UPD:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready       = 1'b0;
        col_start      = 1'b0;
        bank_ctl       = '0;
        upd_fire       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                bank_ctl.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                col_start = in_valid;
            end
            ST_COL:
            begin
                bank_ctl.rd = !col_busy;
            end
            ST_UPD:
            begin
                upd_fire       = slot_free;
                bank_ctl.raise = slot_free && (cmd_reg == CMD_ADD);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign slot_free = !out_valid_reg || out_ready;

    // minimum over the rows, padded leaves read as the largest count
    always_comb
    begin
        for (int i = 0; i < TREE_LEAVES; i++)
        begin
            tree[TREE_LEAVES + i] = CTR_MAX;
        end
        for (int i = 0; i < ROWS; i++)
        begin
            tree[TREE_LEAVES + i] = rd_data[i];
        end
        for (int n = TREE_LEAVES - 1; n >= 1; n--)
        begin
            tree[n] = (tree[2*n] < tree[2*n+1]) ? tree[2*n] : tree[2*n+1];
        end
    end

    always_comb
    begin
        min_next = tree[1];

        sum = SUM_W'(min_reg) + SUM_W'(inc_reg);
        if (sum > SUM_W'(CTR_MAX))
        begin
            target_next = CTR_MAX;
        end
        else
        begin
            target_next = sum[COUNTER_BITS-1:0];
        end

        min_wide = HASH_W'(min_reg);
        if (min_wide > HASH_W'(EST_MAX))
        begin
            estimate_next = EST_MAX;
        end
        else
        begin
            estimate_next = min_wide[EST_W-1:0];
        end

        total_next = total_reg;
        if (upd_fire && (cmd_reg == CMD_ADD))
        begin
            total_next = total_reg + TOTAL_W'(inc_reg);
        end

        clr_addr_next = clr_addr_reg;
        if (state_reg == ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_start)
        begin
            cmd_reg <= cmd;
            inc_reg <= increment;
        end
        if (state_reg == ST_MIN)
        begin
            min_reg <= min_next;
        end
        if (state_reg == ST_TGT)
        begin
            target_reg <= target_next;
        end
        if (upd_fire)
        begin
            estimate_reg <= estimate_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign total     = total_reg;

`ifndef SYNTHESIS
    a_total_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(total_reg) |-> $past(upd_fire && (cmd_reg == CMD_ADD)))
        else $error("running total moved without an add request");

    a_target_not_below_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (target_reg >= min_reg))
        else $error("update target below row minimum");

    a_min_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MIN) |-> $past(bank_ctl.rd))
        else $error("minimum taken without a fresh bank read");
`endif

endmodule

// File: hdl/cms_bank.sv
// ----------------------------------------------------------------------------
// cms_bank
// One row of counters: synchronous read, then a raise-to-target write back.
// ----------------------------------------------------------------------------
module cms_bank
    import cms_pkg::*;
#(
    parameter int ROW_WIDTH    = 1024,
    parameter int COUNTER_BITS = 32,
    localparam int AW          = $clog2(ROW_WIDTH)
)
(
    input  logic                    clk,
    input  cms_bank_ctl_t           ctl,
    input  logic [AW-1:0]           addr,
    input  logic [COUNTER_BITS-1:0] target,
    output logic [COUNTER_BITS-1:0] rd_data
);

    logic [COUNTER_BITS-1:0] mem_reg [ROW_WIDTH];
    logic [COUNTER_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_data_reg <= mem_reg[addr];
        end
        if (ctl.clear)
        begin
            mem_reg[addr] <= '0;
        end
        else if (ctl.raise && (rd_data_reg < target))
        begin
            // conservative update: only counters below the target move
            mem_reg[addr] <= target;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/cms_colmod.sv
// ----------------------------------------------------------------------------
// cms_colmod
// Column unit: per row, (hash_first + r * hash_second) mod ROW_WIDTH.
// ----------------------------------------------------------------------------
module cms_colmod
    import cms_pkg::*;
#(
    parameter int ROWS      = 6,
    parameter int ROW_WIDTH = 1024,
    localparam int CW       = $clog2(ROW_WIDTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [HASH_W-1:0]       hash_first,
    input  logic [HASH_W-1:0]       hash_second,
    output logic                    busy,
    output logic [ROWS-1:0][CW-1:0] col
);

    logic [ROWS-1:0][HASH_W-1:0] pos;

    for (genvar r = 0; r < ROWS; r++)
    begin : g_pos
        assign pos[r] = hash_first + hash_second * HASH_W'(r);
    end

    if ((ROW_WIDTH & (ROW_WIDTH - 1)) == 0)
    begin : g_pow2
        logic [ROWS-1:0][CW-1:0] low_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                low_reg <= '0;
            end
            else if (start)
            begin
                for (int i = 0; i < ROWS; i++)
                begin
                    low_reg[i] <= pos[i][CW-1:0];
                end
            end
        end

        assign col  = low_reg;
        assign busy = 1'b0;
    end
    else
    begin : g_serial
        localparam int STEPS = HASH_W / COL_DIGIT_BITS;
        localparam int CNT_W = $clog2(STEPS);
        localparam logic [CW:0] WIDTH_EXT = (CW + 1)'(ROW_WIDTH);

        logic                        busy_reg, busy_next;
        logic [CNT_W-1:0]            step_cnt_reg, step_cnt_next;
        logic [ROWS-1:0][CW-1:0]     rem_reg, rem_next;
        logic [ROWS-1:0][HASH_W-1:0] sh_reg, sh_next;

        // msb first, one compare-subtract per hash bit
        always_comb
        begin
            logic [CW:0]   t;
            logic [CW-1:0] r;
            t = '0;
            r = '0;
            for (int i = 0; i < ROWS; i++)
            begin
                r = rem_reg[i];
                for (int b = 0; b < COL_DIGIT_BITS; b++)
                begin
                    t = {r, sh_reg[i][HASH_W-1-b]};
                    if (t >= WIDTH_EXT)
                    begin
                        t = t - WIDTH_EXT;
                    end
                    r = t[CW-1:0];
                end
                rem_next[i] = r;
                sh_next[i]  = sh_reg[i] << COL_DIGIT_BITS;
            end
        end

        always_comb
        begin
            busy_next     = busy_reg;
            step_cnt_next = step_cnt_reg;
            if (start)
            begin
                busy_next     = 1'b1;
                step_cnt_next = '0;
            end
            else if (busy_reg)
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_next = 1'b0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg     <= 1'b0;
                step_cnt_reg <= '0;
                rem_reg      <= '0;
            end
            else
            begin
                busy_reg     <= busy_next;
                step_cnt_reg <= step_cnt_next;
                if (start)
                begin
                    rem_reg <= '0;
                end
                else if (busy_reg)
                begin
                    rem_reg <= rem_next;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                sh_reg <= pos;
            end
            else if (busy_reg)
            begin
                sh_reg <= sh_next;
            end
        end

        assign col  = rem_reg;
        assign busy = busy_reg;
    end

`ifndef SYNTHESIS
    for (genvar i = 0; i < ROWS; i++)
    begin : g_chk
        a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
            (32'(col[i]) < 32'(ROW_WIDTH)))
            else $error("column index beyond row width");
    end
`endif

endmodule
